// ===== rtl/core/bst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// Shared codes, widths and types of the bounded set table.
// ----------------------------------------------------------------------------
package bst_pkg;

	// entry and key width
	localparam int DATA_W = 32;

	// action codes
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_SEARCH = 2'd2;
	localparam logic [1:0] ACT_STATUS = 2'd3;

	// width of the reported count
	localparam int COUNT_W = 6;

	// stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 80;

	// running state of one table scan
	typedef struct packed {
		logic              found;  // key matched a stored entry
		logic              any;    // at least one entry other than key seen
		logic [DATA_W-1:0] lo;     // smallest entry other than key
		logic [DATA_W-1:0] hi;     // largest entry other than key
	} scan_res_t;

endpackage

// ===== rtl/core/bst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/bst_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_scan
// Shared compare unit: matches each read entry against the key and keeps the
// running minimum and maximum of the entries that differ from the key.
// ----------------------------------------------------------------------------
module bst_scan #(
	parameter int AW = 5
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  logic                       vld,
	input  logic [bst_pkg::DATA_W-1:0] data,
	input  logic [AW-1:0]              idx,
	input  logic [bst_pkg::DATA_W-1:0] key,
	output bst_pkg::scan_res_t         res,
	output logic [AW-1:0]              slot
);

	logic      hit;
	logic      lt;
	logic      gt;
	logic      found_q;
	logic      any_q;
	logic [bst_pkg::DATA_W-1:0] lo_q;
	logic [bst_pkg::DATA_W-1:0] hi_q;
	logic [AW-1:0] slot_q;

	// one equality and two signed magnitude compares
	assign hit = (data == key);
	assign lt  = ($signed(data) < $signed(lo_q));
	assign gt  = ($signed(data) > $signed(hi_q));

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			any_q   <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
			any_q   <= 1'b0;
		end else if (vld) begin
			if (hit) begin
				found_q <= 1'b1;
			end else begin
				any_q <= 1'b1;
			end
		end
	end

	// running extremes and match slot
	always_ff @(posedge clk) begin
		if (vld && !clear) begin
			if (hit) begin
				slot_q <= idx;
			end else begin
				if (!any_q || lt) begin
					lo_q <= data;
				end
				if (!any_q || gt) begin
					hi_q <= data;
				end
			end
		end
	end

	assign res.found = found_q;
	assign res.any   = any_q;
	assign res.lo    = lo_q;
	assign res.hi    = hi_q;
	assign slot      = slot_q;

endmodule

// ===== rtl/core/bounded_set_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_set_table_core
// Fixed-capacity unordered set of signed 32-bit keys with add, remove,
// search and status requests, each answered by one result.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on the s_ group (action and key in s_tdata) when
//   s_tvalid and s_tready are both high. The block then reads every stored
//   entry once through a single RAM read port and one shared compare unit,
//   which finds the key and tracks minimum and maximum in the same pass.
//   A write-back cycle appends the key (add) or moves the last entry into
//   the freed slot (remove), and the result is loaded into the m_ output
//   register.
//   The time from acceptance to a valid result grows with the number of
//   stored entries, as the scan reads each of them. s_tready is high only
//   while no request is in work, so the next request can be taken as soon
//   as a result loads.
//   If the receiver stalls, the pending result holds in the output register;
//   one further request may be scanned meanwhile and waits in its write-back
//   step until the register frees up.
//   Reset empties the table at once (count zero); RAM contents are not
//   cleared, as only written slots are ever read.
// ----------------------------------------------------------------------------
module bounded_set_table_core #(
	parameter int CAPACITY = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request: [1:0] action, [33:2] key
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bst_pkg::IN_TDATA_W-1:0]  s_tdata,
	// result: [0] ok, [6:1] count, [7] is_empty, [8] is_full,
	//         [40:9] min_value, [72:41] max_value
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bst_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;

	logic [1:0]                 state_q;
	logic [1:0]                 action_q;
	logic [bst_pkg::DATA_W-1:0] key_q;
	logic [CW-1:0]              held_q;
	logic [CW-1:0]              rd_idx_q;
	logic                       rd_vld_s1;
	logic [CW-1:0]              rd_idx_s1;
	logic [bst_pkg::DATA_W-1:0] last_q;
	logic [CW-1:0]              held_m1;
	logic                       s_acc;
	logic                       rd_issue;
	logic                       commit;
	logic                       add_ok;
	logic                       rem_ok;
	logic                       ok;
	logic                       incl;
	logic [CW-1:0]              held_nx;
	logic [CW+5:0]              held_ext;
	logic [bst_pkg::DATA_W-1:0] lo_nx;
	logic [bst_pkg::DATA_W-1:0] hi_nx;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [bst_pkg::DATA_W-1:0] ram_wdata;
	logic [bst_pkg::DATA_W-1:0] ram_rdata;
	logic [AW-1:0]              slot;
	bst_pkg::scan_res_t         scan;
	logic                       m_tvalid_q;
	logic [bst_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	// handshake
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign held_m1  = held_q - 1'b1;
	assign rd_issue = (state_q == ST_SCAN) && (rd_idx_q != held_q);

	// step decision
	assign add_ok = (action_q == bst_pkg::ACT_ADD) && (held_q != CAP_CNT) && !scan.found;
	assign rem_ok = (action_q == bst_pkg::ACT_REMOVE) && scan.found;
	assign ok     = add_ok || rem_ok ||
		(action_q == bst_pkg::ACT_SEARCH && scan.found);
	assign commit = (state_q == ST_WRITE) && (!m_tvalid_q || m_tready);

	always_comb begin
		held_nx = held_q;
		if (add_ok) begin
			held_nx = held_q + 1'b1;
		end else if (rem_ok) begin
			held_nx = held_m1;
		end
	end

	assign held_ext = {6'd0, held_nx};

	// extremes after the step: key counts when it stays or becomes stored
	assign incl = (scan.found && !rem_ok) || add_ok;
	always_comb begin
		lo_nx = scan.lo;
		hi_nx = scan.hi;
		if (held_nx == '0) begin
			lo_nx = '0;
			hi_nx = '0;
		end else if (!scan.any) begin
			lo_nx = key_q;
			hi_nx = key_q;
		end else if (incl) begin
			if ($signed(key_q) < $signed(scan.lo)) begin
				lo_nx = key_q;
			end
			if ($signed(key_q) > $signed(scan.hi)) begin
				hi_nx = key_q;
			end
		end
	end

	// write-back port
	assign ram_we    = commit && (add_ok || rem_ok);
	assign ram_waddr = add_ok ? held_q[AW-1:0] : slot;
	assign ram_wdata = add_ok ? key_q : last_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			held_q    <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (!rd_vld_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (commit) begin
						held_q  <= held_nx;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, read index and last entry
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
		if (s_acc) begin
			action_q <= s_tdata[1:0];
			key_q    <= s_tdata[33:2];
		end
		if (rd_vld_s1 && rd_idx_s1 == held_m1) begin
			last_q <= ram_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {7'd0, hi_nx, lo_nx, (held_nx == CAP_CNT),
				(held_nx == '0), held_ext[5:0], ok};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// entry storage
	bst_ram #(
		.WIDTH (bst_pkg::DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// shared compare unit
	bst_scan #(
		.AW (AW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (s_acc),
		.vld    (rd_vld_s1),
		.data   (ram_rdata),
		.idx    (rd_idx_s1[AW-1:0]),
		.key    (key_q),
		.res    (scan),
		.slot   (slot)
	);

	// count never passes capacity
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CAP_CNT)
		else $error("held count above capacity");

	// count changes only on a committed write-back
	a_held_commit: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != $past(held_q) |-> $past(commit))
		else $error("held count changed outside write-back");

	// a successful add grows the table by one
	a_add_grow: assert property (@(posedge clk) disable iff (!arst_n)
		commit && add_ok |=> held_q == $past(held_q) + 1'b1)
		else $error("add did not grow the table");

	// reads stay below the count
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> rd_idx_q < held_q)
		else $error("read beyond stored entries");

endmodule

// ===== tb/bst_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_table_checker
// Passive checker for the bounded set table: it keeps its own copy of the
// table, works out the status each accepted request should return and
// compares every returned status with the oldest one still owed.
// ----------------------------------------------------------------------------
module bst_table_checker #(
	parameter int CAPACITY = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request: [1:0] action, [33:2] key
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [bst_pkg::IN_TDATA_W-1:0]  s_tdata,
	// result: [0] ok, [6:1] count, [7] is_empty, [8] is_full,
	//         [40:9] min_value, [72:41] max_value
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [bst_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                              fail_count,
	output int                              pending
);

	// status that one request should produce
	typedef struct packed {
		logic                        ok;
		logic [bst_pkg::COUNT_W-1:0] count;
		logic                        empty;
		logic                        full;
		logic [bst_pkg::DATA_W-1:0]  lo;
		logic [bst_pkg::DATA_W-1:0]  hi;
	} table_status_t;

	// shadow table contents and fill level
	logic signed [bst_pkg::DATA_W-1:0] shadow_slots [CAPACITY];
	int                                shadow_held;

	table_status_t owed_status_q [$];
	int            errors    = 0;
	int            result_no = 0;

	assign fail_count = errors;

	// apply one request to the shadow table and return its status
	function automatic table_status_t step_table(input logic [1:0] act,
			input logic signed [bst_pkg::DATA_W-1:0] key);
		table_status_t                     st;
		int                                slot;
		int                                i;
		logic signed [bst_pkg::DATA_W-1:0] lo;
		logic signed [bst_pkg::DATA_W-1:0] hi;
		slot = shadow_held;
		for (i = 0; i < shadow_held; i++)
			if (slot == shadow_held && shadow_slots[i] == key)
				slot = i;
		st.ok = 1'b0;
		case (act)
			bst_pkg::ACT_ADD: begin
				if (shadow_held < CAPACITY && slot == shadow_held) begin
					shadow_slots[shadow_held] = key;
					shadow_held++;
					st.ok = 1'b1;
				end
			end
			bst_pkg::ACT_REMOVE: begin
				// last entry fills the freed slot
				if (slot < shadow_held) begin
					shadow_slots[slot] = shadow_slots[shadow_held-1];
					shadow_held--;
					st.ok = 1'b1;
				end
			end
			bst_pkg::ACT_SEARCH: st.ok = (slot < shadow_held);
			default: ;
		endcase
		// extremes over what is left, zero when empty
		lo = '0;
		hi = '0;
		if (shadow_held > 0) begin
			lo = shadow_slots[0];
			hi = shadow_slots[0];
			for (i = 1; i < shadow_held; i++) begin
				if (shadow_slots[i] < lo)
					lo = shadow_slots[i];
				if (shadow_slots[i] > hi)
					hi = shadow_slots[i];
			end
		end
		st.lo    = lo;
		st.hi    = hi;
		st.count = bst_pkg::COUNT_W'(shadow_held);
		st.empty = (shadow_held == 0);
		st.full  = (shadow_held == CAPACITY);
		return st;
	endfunction

	// one line per mismatch
	task automatic flag_mismatch(input string msg);
		errors++;
		$display("[%0t] result %0d: %s", $time, result_no, msg);
	endtask

	// compare one returned status field by field
	task automatic check_status(input logic [bst_pkg::OUT_TDATA_W-1:0] d);
		table_status_t w;
		if (owed_status_q.size() == 0) begin
			flag_mismatch("result with no request outstanding");
		end else begin
			w = owed_status_q.pop_front();
			if (d[0] !== w.ok)
				flag_mismatch($sformatf("ok %0b, expected %0b", d[0], w.ok));
			if (d[6:1] !== w.count)
				flag_mismatch($sformatf("count %0d, expected %0d", d[6:1], w.count));
			if (d[7] !== w.empty)
				flag_mismatch($sformatf("is_empty %0b, expected %0b", d[7], w.empty));
			if (d[8] !== w.full)
				flag_mismatch($sformatf("is_full %0b, expected %0b", d[8], w.full));
			if (d[40:9] !== w.lo)
				flag_mismatch($sformatf("min_value %h, expected %h", d[40:9], w.lo));
			if (d[72:41] !== w.hi)
				flag_mismatch($sformatf("max_value %h, expected %h", d[72:41], w.hi));
		end
		result_no++;
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_held = 0;
			owed_status_q.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_status(m_tdata);
			if (s_tvalid && s_tready)
				owed_status_q.push_back(step_table(s_tdata[1:0], s_tdata[33:2]));
			pending <= owed_status_q.size();
		end
	end

endmodule

// ===== tb/tb_bounded_set_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_set_table_core
// Drives add, remove, search and status requests into the set table: a
// directed opening on empty, duplicate, missing and extreme keys, then
// random fill, drain and mixed bursts over a small key pool under several
// idle and stall mixes. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bounded_set_table_core;

	localparam int CAPACITY = 32;
	localparam int POOL_N   = 64;
	localparam int LIMIT    = 1000000;
	localparam int PHASE_N  = 481;

	logic                            clk;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [bst_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [bst_pkg::OUT_TDATA_W-1:0] m_tdata;
	int                              fail_count;
	int                              pending;

	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int          cycle_cnt     = 0;
	logic [31:0] key_pool [POOL_N];

	bounded_set_table_core #(.CAPACITY(CAPACITY)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	bst_table_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Some tests failed");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// one request, held until accepted
	task automatic send_request(input logic [1:0] act, input logic [31:0] key);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(bst_pkg::IN_TDATA_W-34){1'b0}}, key, act};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// bursts that fill, drain or mix, keys mostly from the pool
	task automatic random_requests(input int total);
		int          done;
		int          mode;
		int          left;
		int          r;
		logic [1:0]  act;
		logic [31:0] key;
		done = 0;
		while (done < total) begin
			mode = $urandom_range(0, 2);
			left = $urandom_range(30, 90);
			while (left > 0 && done < total) begin
				r = $urandom_range(0, 99);
				case (mode)
					0: act = (r < 80) ? bst_pkg::ACT_ADD :
						(r < 88) ? bst_pkg::ACT_REMOVE :
						(r < 96) ? bst_pkg::ACT_SEARCH : bst_pkg::ACT_STATUS;
					1: act = (r < 15) ? bst_pkg::ACT_ADD :
						(r < 75) ? bst_pkg::ACT_REMOVE :
						(r < 95) ? bst_pkg::ACT_SEARCH : bst_pkg::ACT_STATUS;
					default: act = (r < 30) ? bst_pkg::ACT_ADD :
						(r < 60) ? bst_pkg::ACT_REMOVE :
						(r < 90) ? bst_pkg::ACT_SEARCH : bst_pkg::ACT_STATUS;
				endcase
				if ($urandom_range(0, 99) < 88)
					key = key_pool[$urandom_range(0, POOL_N-1)];
				else
					key = $urandom;
				send_request(act, key);
				done++;
				left--;
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		int p;
		// key pool: extremes and alternating patterns, rest random
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		key_pool[4] = 32'h0000_0001;
		key_pool[5] = 32'h8000_0001;
		key_pool[6] = 32'h5555_5555;
		key_pool[7] = 32'hAAAA_AAAA;
		for (p = 8; p < POOL_N; p++)
			key_pool[p] = $urandom;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table: status, search and remove all miss
		send_request(bst_pkg::ACT_STATUS, 32'h0000_0000);
		send_request(bst_pkg::ACT_SEARCH, 32'h7FFF_FFFF);
		send_request(bst_pkg::ACT_REMOVE, 32'h8000_0000);
		// extremes in, then a duplicate
		send_request(bst_pkg::ACT_ADD, 32'h8000_0000);
		send_request(bst_pkg::ACT_ADD, 32'h7FFF_FFFF);
		send_request(bst_pkg::ACT_ADD, 32'h0000_0000);
		send_request(bst_pkg::ACT_ADD, 32'hFFFF_FFFF);
		send_request(bst_pkg::ACT_ADD, 32'h8000_0000);
		// hit and miss lookups
		send_request(bst_pkg::ACT_SEARCH, 32'h7FFF_FFFF);
		send_request(bst_pkg::ACT_SEARCH, 32'h0000_0001);
		send_request(bst_pkg::ACT_REMOVE, 32'h0000_0005);
		// remove first slot, then the middle one
		send_request(bst_pkg::ACT_REMOVE, 32'h8000_0000);
		send_request(bst_pkg::ACT_REMOVE, 32'h7FFF_FFFF);
		send_request(bst_pkg::ACT_STATUS, 32'hFFFF_FFFF);
		send_request(bst_pkg::ACT_SEARCH, 32'h8000_0000);
		// drain to empty again
		send_request(bst_pkg::ACT_REMOVE, 32'h0000_0000);
		send_request(bst_pkg::ACT_REMOVE, 32'hFFFF_FFFF);
		send_request(bst_pkg::ACT_STATUS, 32'h5555_5555);

		// random phases under each idle mix
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 50; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 50; end
				default: begin send_idle_pct = 34; stall_pct = 34; end
			endcase
			random_requests(PHASE_N);
		end
		s_tvalid <= 1'b0;

		// wait for every owed result, then a latency's worth of quiet
		do
			@(posedge clk);
		while (pending != 0);
		repeat (CAPACITY + 8) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
